// ===== sv/wsf_pkg.sv =====
// ----------------------------------------------------------------------------
// wsf_pkg
// Shared types and constants of the weighted spectral flux onset detector:
// field widths, saturation limits, the Q1.14 bin weight ROM and the
// controller/datapath command and status structs.
// ----------------------------------------------------------------------------
`default_nettype none

package wsf_pkg;

   localparam int IDX_W     = 6;
   localparam int MAX_BANDS = 1 << IDX_W;
   localparam int BAND_W    = 7;
   localparam int POWER_W   = 40;
   localparam int WEIGHT_W  = 15;
   localparam int PROD_W    = POWER_W + WEIGHT_W;
   localparam int ACC_W     = 62;

   localparam logic [BAND_W-1:0]  BAND_RESET = BAND_W'(MAX_BANDS);
   localparam logic [BAND_W-1:0]  BAND_MIN   = BAND_W'(2);
   localparam logic [BAND_W-1:0]  BAND_MAX   = BAND_W'(MAX_BANDS);
   localparam logic [POWER_W-1:0] POWER_MAX  = '1;
   localparam logic [ACC_W-1:0]   ACC_MAX    = '1;

   // round-half-up(16384 * (2/(10(k-1.3)^2+1) + 1/(0.01(k-45)^2+1))), bin 0 unused
   localparam logic [WEIGHT_W-1:0] WEIGHT_ROM [MAX_BANDS] = '{
      15'd0,     15'd18051, 15'd6395,  15'd1975,  15'd1363,  15'd1201,  15'd1158,  15'd1162,
      15'd1188,  15'd1229,  15'd1280,  15'd1339,  15'd1407,  15'd1482,  15'd1565,  15'd1656,
      15'd1756,  15'd1867,  15'd1988,  15'd2122,  15'd2269,  15'd2432,  15'd2612,  15'd2812,
      15'd3035,  15'd3283,  15'd3559,  15'd3869,  15'd4216,  15'd4607,  15'd5045,  15'd5539,
      15'd6094,  15'd6718,  15'd7417,  15'd8195,  15'd9055,  15'd9993,  15'd10998, 15'd12049,
      15'd13109, 15'd14126, 15'd15033, 15'd15756, 15'd16224, 15'd16386, 15'd16223, 15'd15755,
      15'd15033, 15'd14126, 15'd13109, 15'd12048, 15'd10997, 15'd9991,  15'd9053,  15'd8193,
      15'd7415,  15'd6716,  15'd6092,  15'd5536,  15'd5042,  15'd4603,  15'd4213,  15'd3865
   };

   typedef struct packed {
      logic load;
      logic square;
      logic rise;
      logic scale;
      logic acc;
   } wsf_cmd_type;

   typedef struct packed {
      logic item_active;
      logic item_last;
      logic out_free;
   } wsf_status_type;

endpackage

`default_nettype wire

// ===== sv/wsf_ram.sv =====
// ----------------------------------------------------------------------------
// wsf_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module wsf_ram #(
   parameter int WIDTH = 40,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== sv/wsf_ctrl.sv =====
// ----------------------------------------------------------------------------
// wsf_ctrl
// Sequencer of the onset detector: accepts a bin, steps it through square,
// rise, scale and accumulate, and holds the last bin of a frame until the
// output register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module wsf_ctrl
   import wsf_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   output logic                req_stall,
   input  wsf_status_type      status,
   output wsf_cmd_type         cmd
);

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_SQUARE = 5'b00010,
      S_RISE   = 5'b00100,
      S_SCALE  = 5'b01000,
      S_ACC    = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic      finish_ok;
   logic      take;

   assign finish_ok = !status.item_last || status.out_free;

   always_comb begin
      case (state_ff)
         S_IDLE:  take = 1'b1;
         S_ACC:   take = finish_ok;
         default: take = 1'b0;
      endcase
   end

   assign req_stall  = !take;
   assign cmd.load   = req_valid && take && status.item_active;
   assign cmd.square = (state_ff == S_SQUARE);
   assign cmd.rise   = (state_ff == S_RISE);
   assign cmd.scale  = (state_ff == S_SCALE);
   assign cmd.acc    = (state_ff == S_ACC) && finish_ok;

   always_comb begin
      case (state_ff)
         S_IDLE: begin
            state_in = cmd.load ? S_SQUARE : S_IDLE;
         end
         S_SQUARE: state_in = S_RISE;
         S_RISE:   state_in = S_SCALE;
         S_SCALE:  state_in = S_ACC;
         S_ACC: begin
            if (finish_ok) begin
               state_in = cmd.load ? S_SQUARE : S_IDLE;
            end else begin
               state_in = S_ACC;
            end
         end
         default:  state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef SYNTHESIS
   a_load_starts: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> state_ff == S_SQUARE)
      else $error("loaded bin did not enter square step");
   a_square_then_rise: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SQUARE |=> state_ff == S_RISE && $past(state_ff) == S_SQUARE)
      else $error("square step not followed by rise step");
   a_emit_needs_room: assert property (@(posedge clock) disable iff (reset)
      cmd.acc && status.item_last |-> status.out_free)
      else $error("frame result emitted into a full output register");
`endif

endmodule

`default_nettype wire

// ===== sv/wsf_dpath.sv =====
// ----------------------------------------------------------------------------
// wsf_dpath
// Datapath of the onset detector: band count register, bin magnitudes,
// squaring, previous-power memory, rise, weighting and the saturating
// frame accumulator with its output register.
// ----------------------------------------------------------------------------
`default_nettype none

module wsf_dpath
   import wsf_pkg::*;
#(
   parameter int SAMPLE_WIDTH = 20
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    csr_valid,
   output logic                         csr_ready,
   input  wire logic [BAND_W-1:0]       csr_band_count,
   input  wire logic [IDX_W-1:0]        req_bin_index,
   input  wire logic [SAMPLE_WIDTH-1:0] req_bin_real,
   input  wire logic [SAMPLE_WIDTH-1:0] req_bin_imag,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output logic      [ACC_W-1:0]        rsp_onset_strength,
   input  wsf_cmd_type                  cmd,
   output wsf_status_type               status
);

   localparam int SQ_W  = 2 * SAMPLE_WIDTH;
   localparam int SUM_W = SQ_W + 1;
   localparam int EXT_W = (SUM_W > POWER_W) ? SUM_W : POWER_W + 1;

   logic [BAND_W-1:0]       band_ff;
   logic [BAND_W-1:0]       band_eff;
   logic [SAMPLE_WIDTH-1:0] mag_re_in, mag_im_in;
   logic [SAMPLE_WIDTH-1:0] mag_re_ff, mag_im_ff;
   logic [IDX_W-1:0]        idx_ff;
   logic                    last_ff;
   logic [SQ_W-1:0]         sq_re_ff, sq_im_ff;
   logic [MAX_BANDS-1:0]    seen_ff;
   logic                    prev_seen_ff;
   logic [POWER_W-1:0]      prev_rd;
   logic [POWER_W-1:0]      prev_power;
   logic [EXT_W-1:0]        sum_ext;
   logic [POWER_W-1:0]      power_in;
   logic [POWER_W-1:0]      rise_in, rise_ff;
   logic [PROD_W-1:0]       prod_ff;
   logic [ACC_W:0]          acc_sum;
   logic [ACC_W-1:0]        acc_in, acc_ff;
   logic [ACC_W-1:0]        out_ff;
   logic                    rsp_valid_ff;

   always_comb begin
      if (band_ff < BAND_MIN) begin
         band_eff = BAND_MIN;
      end else if (band_ff > BAND_MAX) begin
         band_eff = BAND_MAX;
      end else begin
         band_eff = band_ff;
      end
   end

   assign csr_ready          = 1'b1;
   assign status.item_active = (req_bin_index != '0) && (BAND_W'(req_bin_index) < band_eff);
   assign status.item_last   = last_ff;
   assign status.out_free    = !rsp_valid_ff || !rsp_stall;

   assign mag_re_in = req_bin_real[SAMPLE_WIDTH-1] ? (~req_bin_real + SAMPLE_WIDTH'(1))
                                                    : req_bin_real;
   assign mag_im_in = req_bin_imag[SAMPLE_WIDTH-1] ? (~req_bin_imag + SAMPLE_WIDTH'(1))
                                                    : req_bin_imag;

   wsf_ram #(
      .WIDTH (POWER_W),
      .DEPTH (MAX_BANDS)
   ) u_prev_ram (
      .clock   (clock),
      .wr_en   (cmd.rise),
      .wr_addr (idx_ff),
      .wr_data (power_in),
      .rd_en   (cmd.load),
      .rd_addr (req_bin_index),
      .rd_data (prev_rd)
   );

   assign prev_power = prev_seen_ff ? prev_rd : '0;
   assign sum_ext    = EXT_W'(sq_re_ff) + EXT_W'(sq_im_ff);
   assign power_in   = (sum_ext > EXT_W'(POWER_MAX)) ? POWER_MAX : sum_ext[POWER_W-1:0];
   assign rise_in    = (power_in > prev_power) ? (power_in - prev_power) : '0;

   assign acc_sum = (ACC_W + 1)'(acc_ff) + (ACC_W + 1)'(prod_ff);
   assign acc_in  = (acc_sum > (ACC_W + 1)'(ACC_MAX)) ? ACC_MAX : acc_sum[ACC_W-1:0];

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mag_re_ff    <= mag_re_in;
         mag_im_ff    <= mag_im_in;
         idx_ff       <= req_bin_index;
         last_ff      <= (BAND_W'(req_bin_index) == band_eff - BAND_W'(1));
         prev_seen_ff <= seen_ff[req_bin_index];
      end
      if (cmd.square) begin
         sq_re_ff <= SQ_W'(mag_re_ff) * SQ_W'(mag_re_ff);
         sq_im_ff <= SQ_W'(mag_im_ff) * SQ_W'(mag_im_ff);
      end
      if (cmd.rise) begin
         rise_ff <= rise_in;
      end
      if (cmd.scale) begin
         prod_ff <= PROD_W'(rise_ff) * PROD_W'(WEIGHT_ROM[idx_ff]);
      end
      if (cmd.acc && last_ff) begin
         out_ff <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         band_ff      <= BAND_RESET;
         seen_ff      <= '0;
         acc_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            band_ff <= csr_band_count;
         end
         if (cmd.rise) begin
            seen_ff[idx_ff] <= 1'b1;
         end
         if (cmd.acc) begin
            acc_ff <= last_ff ? '0 : acc_in;
         end
         rsp_valid_ff <= (cmd.acc && last_ff) || (rsp_valid_ff && rsp_stall);
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_onset_strength = out_ff;

`ifndef SYNTHESIS
   a_power_recorded: assert property (@(posedge clock) disable iff (reset)
      cmd.rise |=> seen_ff[$past(idx_ff)])
      else $error("stored power of bin not marked as written");
   a_acc_cleared: assert property (@(posedge clock) disable iff (reset)
      cmd.acc && last_ff |=> acc_ff == '0 && rsp_valid_ff)
      else $error("frame end did not clear accumulator and present result");
   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |=> rsp_valid_ff && $stable(out_ff))
      else $error("stalled frame result changed or dropped");
`endif

endmodule

`default_nettype wire

// ===== sv/weighted_spectral_flux_top.sv =====
// ----------------------------------------------------------------------------
// weighted_spectral_flux_top
// Weighted spectral flux onset detector.
//
// Usage:
//   req_*  : one FFT bin per transaction (index, real, imag), valid/stall.
//   rsp_*  : one onset_strength transaction per frame, after the bin whose
//            index is band_count-1 (band_count taken as 2..64); valid/stall.
//   csr_*  : write of band_count (valid/ready, always ready); write it only
//            while the block is idle.
// Timing:
//   A processed bin steps through the square, rise, scale and accumulate
//   steps; the next bin is accepted in the accumulate step of the last one.
//   Bin 0 and bins at or beyond band_count are accepted and dropped at
//   one per cycle while no bin is being processed.
//   The frame result is written to the output register in the accumulate
//   step of the last bin.
// Reset clears the accumulator, marks every stored bin power as zero and
// sets band_count to 64. While the output register holds an untaken result,
// the last bin of the next frame waits in its accumulate step and req_stall
// stays high.
// ----------------------------------------------------------------------------
`default_nettype none

module weighted_spectral_flux_top
   import wsf_pkg::*;
#(
   parameter int SAMPLE_WIDTH = 20
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    csr_valid,
   output logic                         csr_ready,
   input  wire logic [BAND_W-1:0]       csr_band_count,
   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  wire logic [IDX_W-1:0]        req_bin_index,
   input  wire logic [SAMPLE_WIDTH-1:0] req_bin_real,
   input  wire logic [SAMPLE_WIDTH-1:0] req_bin_imag,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output logic      [ACC_W-1:0]        rsp_onset_strength
);

   wsf_cmd_type    cmd;
   wsf_status_type status;

   wsf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   wsf_dpath #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_dpath (
      .clock              (clock),
      .reset              (reset),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_band_count     (csr_band_count),
      .req_bin_index      (req_bin_index),
      .req_bin_real       (req_bin_real),
      .req_bin_imag       (req_bin_imag),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_onset_strength (rsp_onset_strength),
      .cmd                (cmd),
      .status             (status)
   );

endmodule

`default_nettype wire
